### design/bvsff_pkg.sv
// Shared types, constants and helper functions for the bit vector store.
package bvsff_pkg;

  localparam int MAX_BITS   = 1024;
  localparam int FIELD_BITS = 32;
  localparam int WORD_W     = 32;
  localparam int NWORDS     = MAX_BITS / WORD_W;
  localparam int ADDR_W     = $clog2(NWORDS);
  localparam int OFF_W      = $clog2(WORD_W);
  localparam int POS_W      = $clog2(MAX_BITS);
  localparam int LEN_W      = POS_W + 1;
  localparam int SIZE_W     = 6;

  // Command codes carried in the input tuser
  typedef enum logic [2:0] {
    CMD_TEST  = 3'd0,
    CMD_SET   = 3'd1,
    CMD_CLR   = 3'd2,
    CMD_FIND1 = 3'd3,
    CMD_FIND0 = 3'd4,
    CMD_WRITE = 3'd5,
    CMD_READ  = 3'd6,
    CMD_NONE  = 3'd7
  } cmd_t;

  // Word request from the sequencer to the store
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } bvsff_req_t;

  // Per-word summary flags and current length
  typedef struct packed {
    logic [NWORDS-1:0] nz;   // word holds a set bit
    logic [NWORDS-1:0] hc;   // word holds a clear bit below the length
    logic [LEN_W-1:0]  len;
  } bvsff_stat_t;

  // Mask of the low n bits, n from 0 to 32
  function automatic logic [WORD_W-1:0] low_mask(input logic [SIZE_W-1:0] n);
    logic [WORD_W-1:0] m;
    if (n >= SIZE_W'(WORD_W)) m = '1;
    else m = (WORD_W'(1) << n[OFF_W-1:0]) - WORD_W'(1);
    return m;
  endfunction

  // Lowest set bit: {found, index}
  function automatic logic [OFF_W:0] first_set(input logic [WORD_W-1:0] v);
    logic [OFF_W-1:0] idx;
    logic             hit;
    idx = '0;
    hit = |v;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = OFF_W'(i);
    end
    return {hit, idx};
  endfunction

endpackage

### design/bvsff_store.sv
// Word memory of the bit vector with valid bits, summary flags and length register.
module bvsff_store import bvsff_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_len,
  input  bvsff_req_t       req,
  output logic [WORD_W-1:0] rd_data,
  output bvsff_stat_t      stat
);

  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] vld_r;
  logic [NWORDS-1:0] nz_r;
  logic [NWORDS-1:0] hc_r;
  logic [LEN_W-1:0]  len_r;
  logic [WORD_W-1:0] rd_data_r;
  logic [LEN_W-1:0]  len_nxt;
  logic [LEN_W:0]    words_used;
  logic [WORD_W-1:0] vmask;
  logic [LEN_W-OFF_W-1:0] len_words;

  // Saturate the written length and count the words it covers
  assign len_nxt    = (cfg_len > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : cfg_len;
  assign words_used = ({1'b0, len_nxt} + (LEN_W+1)'(WORD_W - 1)) >> OFF_W;
  assign len_words  = len_r[LEN_W-1:OFF_W];

  // Valid bit mask of the word being written
  always_comb begin
    if (len_words > (LEN_W-OFF_W)'(req.wr_addr)) vmask = '1;
    else if (len_words == (LEN_W-OFF_W)'(req.wr_addr))
      vmask = low_mask(SIZE_W'(len_r[OFF_W-1:0]));
    else vmask = '0;
  end

  // Control state: length, valid bits and summary flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      vld_r <= '0;
      nz_r  <= '0;
      hc_r  <= '0;
    end else if (cfg_we) begin
      len_r <= len_nxt;
      vld_r <= '0;
      nz_r  <= '0;
      for (int w = 0; w < NWORDS; w++) begin
        hc_r[w] <= ((LEN_W+1)'(w) < words_used);
      end
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
      nz_r[req.wr_addr]  <= |req.wr_data;
      hc_r[req.wr_addr]  <= ~&(req.wr_data | ~vmask);
    end
  end

  // Memory array, registered read; unwritten words read as zero
  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_data_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : '0;
  end

  assign rd_data  = rd_data_r;
  assign stat.nz  = nz_r;
  assign stat.hc  = hc_r;
  assign stat.len = len_r;

endmodule

### design/bit_vector_store_find_first_top.sv
// Top level: command sequencer and shared word shift/merge unit of the bit vector store.
//
// Commands arrive on the in_ stream (tuser = command, tdata = position, size, value);
// one result word per command leaves on the out_ stream. The bit vector is held
// as 32 words of 32 bits in a store with a read and a write port and registered read.
// Bit test/set/clear and field commands read the word at the start position and the
// next word, shift and merge them in one 64-bit unit; set, clear and write commands
// write back one or two words (RD_LO, RD_HI, MERGE, WR_HI if a write spans two words,
// DONE). Find commands pick the first candidate word from per-word summary flags,
// read it and encode the bit (FIND, FIND_EX, DONE; no FIND_EX when no word matches).
// Rejected and unused commands go straight to DONE. One command is in work at a time;
// in_tready is high only while the sequencer waits for a command.
// A finished result sits in the output register while the next command is
// accepted; if the receiver stalls with a result still waiting, the sequencer
// holds its next result until the output register is free.
// Reset or a cfg_wr_en write empties the store at once (per-word valid bits): no clearing
// pass. The user must write configuration while idle; the block does not enforce it.
module bit_vector_store_find_first_top import bvsff_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,   // bits_in_use
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,      // position[9:0], field_size[15:10], field_value[47:16]
  input  logic [2:0]  in_tuser,      // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata      // accepted[0], bit_value[1], found[2],
                                     // found_index[12:3], field_data[44:13],
                                     // all_set[45], all_clear[46], zero[47]
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_MERGE,
    ST_WR_HI,
    ST_FIND,
    ST_FIND_EX,
    ST_DONE
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic [POS_W-1:0]   pos_r;
  logic [SIZE_W-1:0]  size_r;
  logic [WORD_W-1:0]  val_r;
  logic [WORD_W-1:0]  lo_r;
  logic [WORD_W-1:0]  hi_r;
  logic [ADDR_W-1:0]  widx_r;
  logic               res_acc_r;
  logic               res_bit_r;
  logic               res_found_r;
  logic [POS_W-1:0]   res_idx_r;
  logic [WORD_W-1:0]  res_data_r;
  logic               out_tvalid_r;
  logic [47:0]        out_tdata_r;

  bvsff_req_t         req;
  bvsff_stat_t        stat;
  logic [WORD_W-1:0]  rd_data;

  // Input word fields
  logic [POS_W-1:0]   in_pos;
  logic [SIZE_W-1:0]  in_size;
  logic [WORD_W-1:0]  in_val;
  cmd_t               in_cmd;
  logic               in_is_bit;
  logic [SIZE_W-1:0]  eff_size;
  logic [LEN_W-1:0]   in_end;
  logic               range_ok;

  // Shared shift/merge unit
  logic [ADDR_W-1:0]   wa;
  logic [ADDR_W-1:0]   wa_hi;
  logic [OFF_W-1:0]    off;
  logic [WORD_W-1:0]   hi_word;
  logic [2*WORD_W-1:0] pair;
  logic [2*WORD_W-1:0] shifted;
  logic [2*WORD_W-1:0] ins;
  logic [2*WORD_W-1:0] clr;
  logic [2*WORD_W-1:0] merged;
  logic [WORD_W-1:0]   fmask;
  logic [WORD_W-1:0]   rd_field;
  logic                spans;
  logic                is_write;

  // Find logic
  logic [OFF_W:0]      wsel;
  logic [OFF_W:0]      bsel;
  logic [WORD_W-1:0]   word_vec;
  logic                all_set;
  logic                all_clear;

  bvsff_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_wr_en),
    .cfg_len (cfg_wr_data),
    .req     (req),
    .rd_data (rd_data),
    .stat    (stat)
  );

  // Command decode and range check at accept
  assign in_pos    = in_tdata[9:0];
  assign in_size   = in_tdata[15:10];
  assign in_val    = in_tdata[47:16];
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_is_bit = (in_cmd == CMD_TEST) || (in_cmd == CMD_SET) || (in_cmd == CMD_CLR);
  assign eff_size  = in_is_bit ? SIZE_W'(1) : in_size;
  assign in_end    = {1'b0, in_pos} + LEN_W'(eff_size);
  assign range_ok  = (eff_size != '0) && (eff_size <= SIZE_W'(FIELD_BITS)) &&
                     (in_end <= stat.len);

  // Word pair shift and merge
  assign wa       = pos_r[POS_W-1:OFF_W];
  assign wa_hi    = wa + ADDR_W'(1);
  assign off      = pos_r[OFF_W-1:0];
  assign hi_word  = (wa == ADDR_W'(NWORDS - 1)) ? '0 : rd_data;
  assign pair     = {hi_word, lo_r};
  assign fmask    = low_mask(size_r);
  assign shifted  = pair >> off;
  assign rd_field = shifted[WORD_W-1:0] & fmask;
  assign ins      = {{WORD_W{1'b0}}, val_r & fmask} << off;
  assign clr      = {{WORD_W{1'b0}}, fmask} << off;
  assign merged   = (pair & ~clr) | ins;
  assign spans    = (SIZE_W'(off) + size_r) > SIZE_W'(WORD_W);
  assign is_write = (cmd_r == CMD_SET) || (cmd_r == CMD_CLR) || (cmd_r == CMD_WRITE);

  // First candidate word from flags, then first bit inside it
  assign wsel      = first_set((cmd_r == CMD_FIND1) ? stat.nz : stat.hc);
  assign word_vec  = (cmd_r == CMD_FIND1) ? rd_data : ~rd_data;
  assign bsel      = first_set(word_vec);
  assign all_set   = ~|stat.hc;
  assign all_clear = ~|stat.nz;

  // Store requests per sequencer step
  always_comb begin
    req = '0;
    case (state_r)
      ST_RD_LO: begin
        req.rd_en   = 1'b1;
        req.rd_addr = wa;
      end
      ST_RD_HI: begin
        req.rd_en   = 1'b1;
        req.rd_addr = wa_hi;
      end
      ST_MERGE: begin
        req.wr_en   = is_write;
        req.wr_addr = wa;
        req.wr_data = merged[WORD_W-1:0];
      end
      ST_WR_HI: begin
        req.wr_en   = 1'b1;
        req.wr_addr = wa_hi;
        req.wr_data = hi_r;
      end
      ST_FIND: begin
        req.rd_en   = wsel[OFF_W];
        req.rd_addr = wsel[OFF_W-1:0];
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // Sequencer with result and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // a word leaving frees the output register unless the next one loads now
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r       <= in_cmd;
            pos_r       <= in_pos;
            size_r      <= eff_size;
            val_r       <= in_is_bit ? WORD_W'(in_cmd == CMD_SET) : in_val;
            res_bit_r   <= 1'b0;
            res_found_r <= 1'b0;
            res_idx_r   <= '0;
            res_data_r  <= '0;
            case (in_cmd)
              CMD_FIND1, CMD_FIND0: begin
                res_acc_r <= 1'b1;
                state_r   <= ST_FIND;
              end
              CMD_TEST, CMD_SET, CMD_CLR, CMD_WRITE, CMD_READ: begin
                res_acc_r <= range_ok;
                state_r   <= range_ok ? ST_RD_LO : ST_DONE;
              end
              default: begin
                res_acc_r <= 1'b0;
                state_r   <= ST_DONE;
              end
            endcase
          end
        end
        ST_RD_LO: begin
          state_r <= ST_RD_HI;
        end
        ST_RD_HI: begin
          lo_r    <= rd_data;
          state_r <= ST_MERGE;
        end
        ST_MERGE: begin
          if (cmd_r == CMD_TEST) res_bit_r <= rd_field[0];
          if (cmd_r == CMD_READ) res_data_r <= rd_field;
          hi_r    <= merged[2*WORD_W-1:WORD_W];
          state_r <= (is_write && spans) ? ST_WR_HI : ST_DONE;
        end
        ST_WR_HI: begin
          state_r <= ST_DONE;
        end
        ST_FIND: begin
          widx_r  <= wsel[OFF_W-1:0];
          state_r <= wsel[OFF_W] ? ST_FIND_EX : ST_DONE;
        end
        ST_FIND_EX: begin
          res_found_r <= 1'b1;
          res_idx_r   <= {widx_r, bsel[OFF_W-1:0]};
          state_r     <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {1'b0, all_clear, all_set, res_data_r, res_idx_r,
                             res_found_r, res_bit_r, res_acc_r};
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### sim/bit_vector_store_find_first_top_tb.sv
// Self-checking testbench for the bit vector store with find-first and field access.
module bit_vector_store_find_first_top_tb import bvsff_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 6;
  localparam int MAX_REPORTS = 10;

  // One command word as the sender sees it
  typedef struct {
    cmd_t        cmd;
    logic [9:0]  position;
    logic [5:0]  field_size;
    logic [31:0] field_value;
    bit          drain_first;   // hold off until every result is back
  } cmd_item_t;

  // One result word, unpacked
  typedef struct {
    logic        accepted;
    logic        bit_value;
    logic        found;
    logic [9:0]  found_index;
    logic [31:0] field_data;
    logic        all_set;
    logic        all_clear;
  } store_result_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [10:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;   // position[9:0], field_size[15:10], field_value[47:16]
  logic [2:0]  in_tuser    = '0;   // cmd
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;          // accepted[0], bit_value[1], found[2], found_index[12:3],
                                   // field_data[44:13], all_set[45], all_clear[46]

  // Shadow copy of the store and its length
  logic [MAX_BITS-1:0] shadow_bits = '0;
  int                  shadow_len  = 0;

  cmd_item_t     cmd_queue[$];
  store_result_t pending_results[$];
  cmd_item_t     cmd_on_bus;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int cycle_count   = 0;

  bit_vector_store_find_first_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one command to the shadow store and work out its result word
  function automatic store_result_t predict_store_result(cmd_item_t it);
    store_result_t       r;
    int                  pos;
    int                  size;
    bit                  field_fits;
    logic [MAX_BITS-1:0] valid_mask;
    r          = '{default: '0};
    pos        = int'(it.position);
    size       = int'(it.field_size);
    field_fits = (size >= 1) && (size <= FIELD_BITS) && (pos + size <= shadow_len);
    case (it.cmd)
      CMD_TEST: begin
        if (pos < shadow_len) begin
          r.accepted  = 1'b1;
          r.bit_value = shadow_bits[pos];
        end
      end
      CMD_SET, CMD_CLR: begin
        if (pos < shadow_len) begin
          r.accepted       = 1'b1;
          shadow_bits[pos] = (it.cmd == CMD_SET);
        end
      end
      CMD_FIND1, CMD_FIND0: begin
        r.accepted = 1'b1;
        for (int k = 0; k < shadow_len; k++) begin
          if (!r.found && shadow_bits[k] == (it.cmd == CMD_FIND1)) begin
            r.found       = 1'b1;
            r.found_index = 10'(k);
          end
        end
      end
      CMD_WRITE: begin
        if (field_fits) begin
          r.accepted = 1'b1;
          for (int k = 0; k < size; k++) shadow_bits[pos + k] = it.field_value[k];
        end
      end
      CMD_READ: begin
        if (field_fits) begin
          r.accepted = 1'b1;
          for (int k = 0; k < size; k++) r.field_data[k] = shadow_bits[pos + k];
        end
      end
      default: ;
    endcase
    // summary flags over the valid bits, after the command
    valid_mask  = (shadow_len >= MAX_BITS) ? '1 : ((MAX_BITS'(1) << shadow_len) - MAX_BITS'(1));
    r.all_set   = ((shadow_bits & valid_mask) == valid_mask);
    r.all_clear = ((shadow_bits & valid_mask) == '0);
    return r;
  endfunction

  function automatic cmd_item_t make_cmd(cmd_t c, int pos, int size, logic [31:0] val);
    cmd_item_t it;
    it.cmd         = c;
    it.position    = 10'(pos);
    it.field_size  = 6'(size);
    it.field_value = val;
    it.drain_first = 1'b0;
    return it;
  endfunction

  // Mostly in-range commands with random content, some out of range
  function automatic cmd_item_t random_cmd(int len);
    cmd_item_t it;
    int        w;
    int        fs;
    w = $urandom_range(0, 99);
    if (w < 15)      it.cmd = CMD_TEST;
    else if (w < 30) it.cmd = CMD_SET;
    else if (w < 40) it.cmd = CMD_CLR;
    else if (w < 50) it.cmd = CMD_FIND1;
    else if (w < 60) it.cmd = CMD_FIND0;
    else if (w < 80) it.cmd = CMD_WRITE;
    else if (w < 95) it.cmd = CMD_READ;
    else             it.cmd = CMD_NONE;
    fs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, FIELD_BITS);
    it.field_size = 6'(fs);
    case ($urandom_range(0, 3))
      0:       it.field_value = '1;
      1:       it.field_value = '0;
      default: it.field_value = $urandom();
    endcase
    if (len > 0 && $urandom_range(0, 9) != 0) begin
      if ((it.cmd == CMD_WRITE || it.cmd == CMD_READ) && fs <= len)
        it.position = 10'($urandom_range(0, len - fs));
      else
        it.position = 10'($urandom_range(0, len - 1));
    end else begin
      it.position = 10'($urandom_range(0, 1023));
    end
    it.drain_first = ($urandom_range(0, 149) == 0);
    return it;
  endfunction

  // Edge cases for the current length
  task automatic load_directed(int len);
    int fs;
    fs = (len < FIELD_BITS) ? len : FIELD_BITS;
    cmd_queue.push_back(make_cmd(CMD_TEST,  0,        1,  '0));
    cmd_queue.push_back(make_cmd(CMD_SET,   0,        1,  '0));
    cmd_queue.push_back(make_cmd(CMD_SET,   len - 1,  1,  '0));
    cmd_queue.push_back(make_cmd(CMD_TEST,  len - 1,  1,  '0));
    cmd_queue.push_back(make_cmd(CMD_SET,   len,      1,  '0));     // just past the end
    cmd_queue.push_back(make_cmd(CMD_TEST,  len,      1,  '0));
    cmd_queue.push_back(make_cmd(CMD_CLR,   1023,     1,  '0));
    cmd_queue.push_back(make_cmd(CMD_FIND1, 0,        0,  '0));
    cmd_queue.push_back(make_cmd(CMD_FIND0, 0,        0,  '0));
    cmd_queue.push_back(make_cmd(CMD_WRITE, 0,        32, '1));
    cmd_queue.push_back(make_cmd(CMD_WRITE, 0,        0,  '1));     // zero size
    cmd_queue.push_back(make_cmd(CMD_WRITE, 0,        33, '1));     // too wide
    cmd_queue.push_back(make_cmd(CMD_WRITE, len - fs, fs, '1));     // ends on the last bit
    cmd_queue.push_back(make_cmd(CMD_FIND0, 0,        0,  '0));
    // sender waits here until every earlier result is back
    cmd_queue[cmd_queue.size() - 1].drain_first = 1'b1;
    cmd_queue.push_back(make_cmd(CMD_WRITE, len - fs + 1, fs, 32'h5A5A_A5A5)); // one past end
    cmd_queue.push_back(make_cmd(CMD_READ,  0,        32, '0));
    cmd_queue.push_back(make_cmd(CMD_READ,  len - 1,  1,  '0));
    cmd_queue.push_back(make_cmd(CMD_READ,  len - fs + 1, fs, '0));
    cmd_queue.push_back(make_cmd(CMD_READ,  0,        0,  '0));
    cmd_queue.push_back(make_cmd(CMD_NONE,  0,        1,  '1));
    cmd_queue.push_back(make_cmd(CMD_CLR,   0,        1,  '0));
    cmd_queue.push_back(make_cmd(CMD_FIND1, 1023,     63, '1));
    cmd_queue.push_back(make_cmd(CMD_TEST,  1023,     63, '1));
    cmd_queue.push_back(make_cmd(CMD_READ,  1023,     63, '1));
    cmd_queue.push_back(make_cmd(CMD_WRITE, 3,        29, 32'hDEAD_BEEF));
  endtask

  // Length write; only done while the block is idle
  task automatic write_length(int value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 11'(value);
    shadow_len  = (value > MAX_BITS) ? MAX_BITS : value;
    shadow_bits = '0;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d %s: expected 0x%0h, got 0x%0h", results_seen, name, want, got);
    end
  endtask

  // Command driver: predicts on acceptance, then offers the next word
  always @(posedge clk) begin : drive_cmds
    cmd_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        pending_results.push_back(predict_store_result(cmd_on_bus));
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(cmd_queue[0].drain_first && pending_results.size() > 0)) begin
          nxt = cmd_queue.pop_front();
          cmd_on_bus <= nxt;
          in_tvalid  <= 1'b1;
          in_tdata   <= {nxt.field_value, nxt.field_size, nxt.position};
          in_tuser   <= nxt.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : watch_results
    store_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result word 0x%0h", out_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("accepted",    32'(want.accepted),    32'(out_tdata[0]));
          check_field("bit_value",   32'(want.bit_value),   32'(out_tdata[1]));
          check_field("found",       32'(want.found),       32'(out_tdata[2]));
          check_field("found_index", 32'(want.found_index), 32'(out_tdata[12:3]));
          check_field("field_data",  want.field_data,       out_tdata[44:13]);
          check_field("all_set",     32'(want.all_set),     32'(out_tdata[45]));
          check_field("all_clear",   32'(want.all_clear),   32'(out_tdata[46]));
        end
        results_seen++;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bit_vector_store_find_first_top test failed");
      $finish;
    end
  end

  // Reset, then phases of length setting plus stimulus
  initial begin : run_phases
    int lengths[NUM_PHASES];
    int counts[NUM_PHASES];
    lengths = '{MAX_BITS, 0, 2047, 1, 2, MAX_BITS};
    counts  = '{420, 60, 420, 60, 420, 420};
    lengths[4] = $urandom_range(2, 64);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 72;
      end else if (ph < 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_length(lengths[ph]);
      load_directed(shadow_len);
      for (int n = 0; n < counts[ph]; n++) cmd_queue.push_back(random_cmd(shadow_len));
      // drain fully before the next length write; sampled once the edge has settled
      do @(negedge clk);
      while (cmd_queue.size() > 0 || in_tvalid || pending_results.size() > 0);
      repeat (8) @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("bit_vector_store_find_first_top test passed");
    end else begin
      $display("bit_vector_store_find_first_top test failed");
    end
    $finish;
  end

endmodule
